>>> rtl/ddps_pkg.sv
package ddps_pkg;

  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned MAX_DUTY = 255;
  localparam int unsigned REQ_W    = 25;
  localparam int unsigned Q_BITS   = 10;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned GAIN_W   = 10;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [2:0] REG_TURN_THR  = 3'd0;
  localparam logic [2:0] REG_MOVE_THR  = 3'd1;
  localparam logic [2:0] REG_TURN_DUTY = 3'd2;
  localparam logic [2:0] REG_GAIN      = 3'd3;
  localparam logic [2:0] REG_OFFSET    = 3'd4;
  localparam logic [2:0] REG_MIN_DUTY  = 3'd5;
  localparam logic [2:0] REG_RAMP      = 3'd6;
  localparam logic [2:0] REG_TIMEOUT   = 3'd7;

  typedef struct packed {
    logic [THR_W-1:0]  turn_threshold;
    logic [THR_W-1:0]  move_threshold;
    logic [7:0]        turn_duty;
    logic [GAIN_W-1:0] linear_gain;
    logic [7:0]        duty_offset;
    logic [7:0]        min_duty;
    logic [7:0]        ramp_step;
    logic [7:0]        timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic                      kind;
    logic signed [SPEED_W-1:0] linear_speed;
    logic signed [SPEED_W-1:0] turn_rate;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              left_fwd_pin;
    logic              left_rev_pin;
    logic              right_fwd_pin;
    logic              right_rev_pin;
    logic              left_in_reverse;
    logic              right_in_reverse;
  } out_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] level;
    logic              fwd_pin;
    logic              rev_pin;
    logic              reversing;
  } wheel_t;

endpackage

>>> rtl/diff_drive_pwm_slew_driver.sv
// A tick item is held in the input register; its result is then registered in the wheel state registers.
// Throughput: one item per cycle; a tick waits only while an earlier result is not yet taken.
// The wheel state registers double as the result register, so results hold until taken.
// Reset (rst_n low, synchronous): registers to defaults, requests and duty zero,
// pins braked high, idle tick counter saturated at its top value, both channels empty.
module diff_drive_pwm_slew_driver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ddps_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ddps_pkg::out_item_t           out_item,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ddps_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [ddps_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [ddps_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int unsigned RW = ddps_pkg::REQ_W;

  ddps_pkg::cfg_t      cfg;
  ddps_pkg::in_item_t  item_r;
  logic                item_valid_r, out_valid_r;
  logic                adv, is_tick, tick_adv, cmd_adv, timed_out;
  logic signed [RW-1:0] left_req_r, right_req_r, cmd_left, cmd_right;
  logic signed [RW-1:0] left_eff, right_eff;
  logic [7:0]          idle_r, idle_inc;
  ddps_pkg::wheel_t    left_w, right_w;

  ddps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign is_tick  = (item_r.kind == ddps_pkg::KIND_TICK);
  assign adv      = item_valid_r && (!is_tick || !out_valid_r || out_ready);
  assign tick_adv = adv && is_tick;
  assign cmd_adv  = adv && !is_tick;
  assign in_ready = rst_n && (!item_valid_r || adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  ddps_cmd u_cmd (
    .cfg          (cfg),
    .linear_speed (item_r.linear_speed),
    .turn_rate    (item_r.turn_rate),
    .left_req     (cmd_left),
    .right_req    (cmd_right)
  );

  assign idle_inc  = (idle_r == 8'hFF) ? idle_r : idle_r + 8'd1;
  assign timed_out = idle_inc > cfg.timeout_ticks;
  assign left_eff  = timed_out ? '0 : left_req_r;
  assign right_eff = timed_out ? '0 : right_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_req_r  <= '0;
      right_req_r <= '0;
      idle_r      <= 8'hFF;
    end else if (cmd_adv) begin
      left_req_r  <= cmd_left;
      right_req_r <= cmd_right;
      idle_r      <= '0;
    end else if (tick_adv) begin
      left_req_r  <= left_eff;
      right_req_r <= right_eff;
      idle_r      <= idle_inc;
    end
  end

  ddps_wheel u_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (tick_adv),
    .req       (left_eff),
    .ramp_step (cfg.ramp_step),
    .wheel     (left_w)
  );

  ddps_wheel u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (tick_adv),
    .req       (right_eff),
    .ramp_step (cfg.ramp_step),
    .wheel     (right_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_item.left_duty        = left_w.level;
  assign out_item.right_duty       = right_w.level;
  assign out_item.left_fwd_pin     = left_w.fwd_pin;
  assign out_item.left_rev_pin     = left_w.rev_pin;
  assign out_item.right_fwd_pin    = right_w.fwd_pin;
  assign out_item.right_rev_pin    = right_w.rev_pin;
  assign out_item.left_in_reverse  = left_w.reversing;
  assign out_item.right_in_reverse = right_w.reversing;

endmodule

>>> rtl/ddps_cfg.sv
module ddps_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ddps_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [ddps_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [ddps_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output ddps_pkg::cfg_t                cfg
);

  ddps_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     idx;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[ddps_pkg::ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.turn_threshold <= ddps_pkg::THR_W'(102);
      cfg_r.move_threshold <= ddps_pkg::THR_W'(10);
      cfg_r.turn_duty      <= 8'd70;
      cfg_r.linear_gain    <= ddps_pkg::GAIN_W'(400);
      cfg_r.duty_offset    <= 8'd60;
      cfg_r.min_duty       <= 8'd55;
      cfg_r.ramp_step      <= 8'd2;
      cfg_r.timeout_ticks  <= 8'd50;
    end else if (wr_en) begin
      unique case (idx)
        ddps_pkg::REG_TURN_THR:  cfg_r.turn_threshold <= cfg_pwdata[ddps_pkg::THR_W-1:0];
        ddps_pkg::REG_MOVE_THR:  cfg_r.move_threshold <= cfg_pwdata[ddps_pkg::THR_W-1:0];
        ddps_pkg::REG_TURN_DUTY: cfg_r.turn_duty      <= cfg_pwdata[7:0];
        ddps_pkg::REG_GAIN:      cfg_r.linear_gain    <= cfg_pwdata[ddps_pkg::GAIN_W-1:0];
        ddps_pkg::REG_OFFSET:    cfg_r.duty_offset    <= cfg_pwdata[7:0];
        ddps_pkg::REG_MIN_DUTY:  cfg_r.min_duty       <= cfg_pwdata[7:0];
        ddps_pkg::REG_RAMP:      cfg_r.ramp_step      <= cfg_pwdata[7:0];
        ddps_pkg::REG_TIMEOUT:   cfg_r.timeout_ticks  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ddps_pkg::REG_TURN_THR:  cfg_prdata = ddps_pkg::DATA_W'(cfg_r.turn_threshold);
      ddps_pkg::REG_MOVE_THR:  cfg_prdata = ddps_pkg::DATA_W'(cfg_r.move_threshold);
      ddps_pkg::REG_TURN_DUTY: cfg_prdata = ddps_pkg::DATA_W'(cfg_r.turn_duty);
      ddps_pkg::REG_GAIN:      cfg_prdata = ddps_pkg::DATA_W'(cfg_r.linear_gain);
      ddps_pkg::REG_OFFSET:    cfg_prdata = ddps_pkg::DATA_W'(cfg_r.duty_offset);
      ddps_pkg::REG_MIN_DUTY:  cfg_prdata = ddps_pkg::DATA_W'(cfg_r.min_duty);
      ddps_pkg::REG_RAMP:      cfg_prdata = ddps_pkg::DATA_W'(cfg_r.ramp_step);
      ddps_pkg::REG_TIMEOUT:   cfg_prdata = ddps_pkg::DATA_W'(cfg_r.timeout_ticks);
      default:                 cfg_prdata = '0;
    endcase
  end

endmodule

>>> rtl/ddps_cmd.sv
module ddps_cmd (
  input  ddps_pkg::cfg_t                          cfg,
  input  logic signed [ddps_pkg::SPEED_W-1:0]     linear_speed,
  input  logic signed [ddps_pkg::SPEED_W-1:0]     turn_rate,
  output logic signed [ddps_pkg::REQ_W-1:0]       left_req,
  output logic signed [ddps_pkg::REQ_W-1:0]       right_req
);

  localparam int unsigned W17  = ddps_pkg::SPEED_W + 1;
  localparam int unsigned PW   = ddps_pkg::SPEED_W + ddps_pkg::GAIN_W + 1;
  localparam int unsigned LW   = PW + 1;
  localparam int unsigned RW   = ddps_pkg::REQ_W;

  logic signed [W17-1:0] turn_x, speed_x, turn_thr, turn_thr_n;
  logic        [W17-1:0] aspeed;
  logic                  turn_pos, turn_neg, moving;
  logic signed [PW-1:0]  prod;
  logic signed [LW-1:0]  lin;
  logic signed [RW-1:0]  lin_sat, td_pos, td_neg, l_raw, r_raw;
  logic        [RW-1:0]  min_q;

  function automatic logic signed [RW-1:0] min_cut(input logic signed [RW-1:0] v,
                                                   input logic [RW-1:0] lim);
    logic [RW-1:0] mag;
    mag = v[RW-1] ? RW'(-v) : RW'(v);
    return (mag < lim) ? '0 : v;
  endfunction

  assign turn_x     = W17'(turn_rate);
  assign speed_x    = W17'(linear_speed);
  assign turn_thr   = W17'({2'b00, cfg.turn_threshold});
  assign turn_thr_n = -turn_thr;
  assign aspeed     = speed_x[W17-1] ? W17'(-speed_x) : W17'(speed_x);
  assign turn_pos   = turn_x > turn_thr;
  assign turn_neg   = turn_x < turn_thr_n;
  assign moving     = aspeed > W17'(cfg.move_threshold);

  assign prod = PW'(linear_speed) * PW'($signed({1'b0, cfg.linear_gain}));
  assign lin  = LW'(prod) + LW'($signed({1'b0, cfg.duty_offset, {ddps_pkg::Q_BITS{1'b0}}}));

  always_comb begin
    if (lin > LW'(2 ** (RW - 1) - 1)) begin
      lin_sat = {1'b0, {(RW-1){1'b1}}};
    end else if (lin < -LW'(2 ** (RW - 1))) begin
      lin_sat = {1'b1, {(RW-1){1'b0}}};
    end else begin
      lin_sat = lin[RW-1:0];
    end
  end

  assign td_pos = RW'($signed({1'b0, cfg.turn_duty, {ddps_pkg::Q_BITS{1'b0}}}));
  assign td_neg = -td_pos;
  assign min_q  = RW'({cfg.min_duty, {ddps_pkg::Q_BITS{1'b0}}});

  always_comb begin
    if (turn_pos) begin
      l_raw = td_neg;
      r_raw = td_pos;
    end else if (turn_neg) begin
      l_raw = td_pos;
      r_raw = td_neg;
    end else if (moving) begin
      l_raw = lin_sat;
      r_raw = lin_sat;
    end else begin
      l_raw = '0;
      r_raw = '0;
    end
  end

  assign left_req  = min_cut(l_raw, min_q);
  assign right_req = min_cut(r_raw, min_q);

endmodule

>>> rtl/ddps_wheel.sv
module ddps_wheel (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step_en,
  input  logic signed [ddps_pkg::REQ_W-1:0]   req,
  input  logic [7:0]                          ramp_step,
  output ddps_pkg::wheel_t                    wheel
);

  localparam int unsigned RW = ddps_pkg::REQ_W;
  localparam int unsigned DW = ddps_pkg::DUTY_W;
  localparam int unsigned SW = ((DW > 8) ? DW : 8) + 1;

  ddps_pkg::wheel_t wheel_r, wheel_nxt;
  logic [RW-1:0]    mag, lvl_q;
  logic [SW-1:0]    up_sum, lvl_x, step_x;
  logic             rise, fall;

  assign mag    = req[RW-1] ? RW'(-req) : RW'(req);
  assign lvl_q  = RW'({wheel_r.level, {ddps_pkg::Q_BITS{1'b0}}});
  assign rise   = mag > lvl_q;
  assign fall   = mag < lvl_q;
  assign lvl_x  = SW'(wheel_r.level);
  assign step_x = SW'(ramp_step);
  assign up_sum = lvl_x + step_x;

  always_comb begin
    wheel_nxt = wheel_r;
    if (!req[RW-1] && (req != '0)) begin
      wheel_nxt.fwd_pin   = 1'b0;
      wheel_nxt.rev_pin   = 1'b1;
      wheel_nxt.reversing = 1'b0;
    end else if (req[RW-1]) begin
      wheel_nxt.fwd_pin   = 1'b1;
      wheel_nxt.rev_pin   = 1'b0;
      wheel_nxt.reversing = 1'b1;
    end else if (wheel_r.level == '0) begin
      wheel_nxt.fwd_pin = 1'b1;
      wheel_nxt.rev_pin = 1'b1;
    end
    if (rise) begin
      wheel_nxt.level = (up_sum > SW'(ddps_pkg::MAX_DUTY)) ? DW'(ddps_pkg::MAX_DUTY)
                                                            : up_sum[DW-1:0];
    end else if (fall) begin
      wheel_nxt.level = (lvl_x < step_x) ? '0 : DW'(lvl_x - step_x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_r.level     <= '0;
      wheel_r.fwd_pin   <= 1'b1;
      wheel_r.rev_pin   <= 1'b1;
      wheel_r.reversing <= 1'b0;
    end else if (step_en) begin
      wheel_r <= wheel_nxt;
    end
  end

  assign wheel = wheel_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int LEFT = 0;
  localparam int RIGHT = 1;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 1300 / PHASES;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam longint DUTY_TOP = ddps_pkg::MAX_DUTY;

  typedef enum {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SLOW_TOGGLE} rx_mode_t;
  typedef enum {SHAPE_ANY, SHAPE_TURN, SHAPE_MOVE, SHAPE_EDGE} cmd_shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ddps_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ddps_pkg::out_item_t out_item;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ddps_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [ddps_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [ddps_pkg::DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  diff_drive_pwm_slew_driver dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ddps_pkg::cfg_t regs;
  logic signed [ddps_pkg::REQ_W-1:0] wheel_req [2];
  ddps_pkg::wheel_t wheel_st [2];
  logic [7:0] idle_ticks;

  ddps_pkg::in_item_t pending_items [$];
  ddps_pkg::out_item_t expected_results [$];
  int items_pushed = 0;
  int items_taken = 0;
  int ticks_taken = 0;
  int results_checked = 0;
  int fail_count = 0;
  int phases_run = 0;

  function automatic logic signed [ddps_pkg::REQ_W-1:0] shape_request(longint v);
    longint top;
    top = (longint'(1) <<< (ddps_pkg::REQ_W - 1)) - 1;
    if (v > top) v = top;
    else if (v < -top - 1) v = -top - 1;
    if ((v < 0 ? -v : v) < (longint'(regs.min_duty) << ddps_pkg::Q_BITS)) v = 0;
    return v[ddps_pkg::REQ_W-1:0];
  endfunction

  task automatic predict_item(ddps_pkg::in_item_t it);
    longint speed, turn, td, req, mag, lv;
    ddps_pkg::out_item_t res;
    if (it.kind == ddps_pkg::KIND_CMD) begin
      speed = $signed(it.linear_speed);
      turn = $signed(it.turn_rate);
      td = longint'(regs.turn_duty) << ddps_pkg::Q_BITS;
      idle_ticks = '0;
      if (turn > longint'(regs.turn_threshold)) begin
        wheel_req[LEFT] = shape_request(-td);
        wheel_req[RIGHT] = shape_request(td);
      end else if (turn < -longint'(regs.turn_threshold)) begin
        wheel_req[LEFT] = shape_request(td);
        wheel_req[RIGHT] = shape_request(-td);
      end else if ((speed < 0 ? -speed : speed) > longint'(regs.move_threshold)) begin
        req = longint'(regs.linear_gain) * speed
              + (longint'(regs.duty_offset) << ddps_pkg::Q_BITS);
        wheel_req[LEFT] = shape_request(req);
        wheel_req[RIGHT] = shape_request(req);
      end else begin
        wheel_req[LEFT] = '0;
        wheel_req[RIGHT] = '0;
      end
    end else begin
      if (idle_ticks != '1) idle_ticks++;
      if (idle_ticks > regs.timeout_ticks) begin
        wheel_req[LEFT] = '0;
        wheel_req[RIGHT] = '0;
      end
      for (int w = LEFT; w <= RIGHT; w++) begin
        req = wheel_req[w];
        mag = req < 0 ? -req : req;
        lv = wheel_st[w].level;
        if (req > 0) begin
          wheel_st[w].fwd_pin = 1'b0;
          wheel_st[w].rev_pin = 1'b1;
          wheel_st[w].reversing = 1'b0;
        end else if (req < 0) begin
          wheel_st[w].fwd_pin = 1'b1;
          wheel_st[w].rev_pin = 1'b0;
          wheel_st[w].reversing = 1'b1;
        end else if (lv == 0) begin
          wheel_st[w].fwd_pin = 1'b1;
          wheel_st[w].rev_pin = 1'b1;
        end
        if (mag > (lv << ddps_pkg::Q_BITS)) lv = lv + longint'(regs.ramp_step);
        else if (mag < (lv << ddps_pkg::Q_BITS)) lv = lv - longint'(regs.ramp_step);
        if (lv > DUTY_TOP) lv = DUTY_TOP;
        if (lv < 0) lv = 0;
        wheel_st[w].level = lv[ddps_pkg::DUTY_W-1:0];
      end
      res.left_duty = wheel_st[LEFT].level;
      res.right_duty = wheel_st[RIGHT].level;
      res.left_fwd_pin = wheel_st[LEFT].fwd_pin;
      res.left_rev_pin = wheel_st[LEFT].rev_pin;
      res.right_fwd_pin = wheel_st[RIGHT].fwd_pin;
      res.right_rev_pin = wheel_st[RIGHT].rev_pin;
      res.left_in_reverse = wheel_st[LEFT].reversing;
      res.right_in_reverse = wheel_st[RIGHT].reversing;
      expected_results.push_back(res);
    end
  endtask

  function automatic string fmt_result(ddps_pkg::out_item_t r);
    return $sformatf("duty %0d/%0d pins L%b%b R%b%b rev %b%b", r.left_duty, r.right_duty,
                     r.left_fwd_pin, r.left_rev_pin, r.right_fwd_pin, r.right_rev_pin,
                     r.left_in_reverse, r.right_in_reverse);
  endfunction

  task automatic log_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", what);
  endtask

  // input driver
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 1;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_item);
        items_taken++;
        if (in_item.kind == ddps_pkg::KIND_TICK) ticks_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  rx_mode_t rx_mode = RX_ALWAYS;
  int rx_left = 0;
  int rx_cycle = 0;

  always @(posedge clk) begin
    ddps_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          log_failure($sformatf("result with nothing pending: %s", fmt_result(out_item)));
        end else begin
          want = expected_results.pop_front();
          if (out_item !== want)
            log_failure($sformatf("result %0d: expected %s, got %s", results_checked,
                                  fmt_result(want), fmt_result(out_item)));
        end
      end
      rx_cycle <= rx_cycle + 1;
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom());
        RX_PERIODIC: out_ready <= (rx_cycle % 4) != 3;
        default: out_ready <= ($urandom_range(0, 9) == 0) ? ~out_ready : out_ready;
      endcase
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [ddps_pkg::DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      ddps_pkg::REG_TURN_THR: regs.turn_threshold = data[ddps_pkg::THR_W-1:0];
      ddps_pkg::REG_MOVE_THR: regs.move_threshold = data[ddps_pkg::THR_W-1:0];
      ddps_pkg::REG_TURN_DUTY: regs.turn_duty = data[7:0];
      ddps_pkg::REG_GAIN: regs.linear_gain = data[ddps_pkg::GAIN_W-1:0];
      ddps_pkg::REG_OFFSET: regs.duty_offset = data[7:0];
      ddps_pkg::REG_MIN_DUTY: regs.min_duty = data[7:0];
      ddps_pkg::REG_RAMP: regs.ramp_step = data[7:0];
      default: regs.timeout_ticks = data[7:0];
    endcase
  endtask

  task automatic program_regs(ddps_pkg::cfg_t c, bit dirty);
    logic [ddps_pkg::DATA_W-1:0] v;
    logic [ddps_pkg::DATA_W-1:0] junk;
    int w;
    for (int i = ddps_pkg::REG_TURN_THR; i <= ddps_pkg::REG_TIMEOUT; i++) begin
      case (3'(i))
        ddps_pkg::REG_TURN_THR: begin
          v = ddps_pkg::DATA_W'(c.turn_threshold); w = ddps_pkg::THR_W;
        end
        ddps_pkg::REG_MOVE_THR: begin
          v = ddps_pkg::DATA_W'(c.move_threshold); w = ddps_pkg::THR_W;
        end
        ddps_pkg::REG_TURN_DUTY: begin v = ddps_pkg::DATA_W'(c.turn_duty); w = 8; end
        ddps_pkg::REG_GAIN: begin
          v = ddps_pkg::DATA_W'(c.linear_gain); w = ddps_pkg::GAIN_W;
        end
        ddps_pkg::REG_OFFSET: begin v = ddps_pkg::DATA_W'(c.duty_offset); w = 8; end
        ddps_pkg::REG_MIN_DUTY: begin v = ddps_pkg::DATA_W'(c.min_duty); w = 8; end
        ddps_pkg::REG_RAMP: begin v = ddps_pkg::DATA_W'(c.ramp_step); w = 8; end
        default: begin v = ddps_pkg::DATA_W'(c.timeout_ticks); w = 8; end
      endcase
      junk = dirty ? ($urandom() << w) : '0;
      write_reg(3'(i), v | junk);
    end
    phases_run++;
  endtask

  function automatic ddps_pkg::cfg_t random_regs();
    ddps_pkg::cfg_t c;
    c.turn_threshold = ($urandom_range(0, 3) == 0) ? ddps_pkg::THR_W'($urandom())
                                                   : ddps_pkg::THR_W'($urandom_range(0, 1500));
    c.move_threshold = ($urandom_range(0, 3) == 0) ? ddps_pkg::THR_W'($urandom())
                                                   : ddps_pkg::THR_W'($urandom_range(0, 600));
    c.turn_duty = 8'($urandom());
    c.linear_gain = ddps_pkg::GAIN_W'($urandom());
    c.duty_offset = 8'($urandom());
    c.min_duty = ($urandom_range(0, 2) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 80));
    c.ramp_step = ($urandom_range(0, 5) == 0) ? 8'd0 :
                  ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255))
                                              : 8'($urandom_range(1, 8));
    c.timeout_ticks = ($urandom_range(0, 4) == 0) ? 8'hFF : 8'($urandom_range(0, 60));
    return c;
  endfunction

  function automatic ddps_pkg::in_item_t make_item(logic kind, int speed, int turn);
    ddps_pkg::in_item_t it;
    it.kind = kind;
    it.linear_speed = 16'(speed);
    it.turn_rate = 16'(turn);
    return it;
  endfunction

  function automatic int edge_value(int thr);
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return 32767;
      2: return thr;
      3: return -thr;
      4: return thr + 1;
      5: return -thr - 1;
      default: return 0;
    endcase
  endfunction

  task automatic queue_item(ddps_pkg::in_item_t it);
    pending_items.push_back(it);
    items_pushed++;
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_item(make_item(ddps_pkg::KIND_TICK, int'($urandom()), int'($urandom())));
  endtask

  task automatic queue_command();
    int thr, mt, speed, turn;
    cmd_shape_t shape;
    thr = regs.turn_threshold;
    mt = regs.move_threshold;
    shape = cmd_shape_t'($urandom_range(0, 3));
    speed = int'($urandom());
    turn = int'($urandom());
    case (shape)
      SHAPE_TURN: begin
        turn = thr + int'($urandom_range(1, 64));
        if ($urandom_range(0, 1) == 0) turn = -turn;
      end
      SHAPE_MOVE: begin
        turn = int'($urandom_range(0, 2 * thr)) - thr;
        speed = mt + int'($urandom_range(1, 4000));
        if ($urandom_range(0, 1) == 0) speed = -speed;
      end
      SHAPE_EDGE: begin
        speed = edge_value(mt);
        turn = edge_value(thr);
      end
      default: ;
    endcase
    queue_item(make_item(ddps_pkg::KIND_CMD, speed, turn));
  endtask

  task automatic queue_sequence();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) queue_item(make_item(1'($urandom()), int'($urandom()), int'($urandom())));
    end else begin
      queue_command();
      if ($urandom_range(0, 7) == 0) n = int'(regs.timeout_ticks) + int'($urandom_range(0, 3));
      else n = $urandom_range(0, 12);
      if (n > 70) n = 70;
      queue_ticks(n);
    end
  endtask

  task automatic queue_directed();
    queue_ticks(1);
    queue_item(make_item(ddps_pkg::KIND_CMD, 0, 32767));
    queue_ticks(3);
    queue_item(make_item(ddps_pkg::KIND_CMD, 0, -32768));
    queue_ticks(2);
    queue_item(make_item(ddps_pkg::KIND_CMD, 0, 102));
    queue_ticks(1);
    queue_item(make_item(ddps_pkg::KIND_CMD, 5, -103));
    queue_ticks(1);
    queue_item(make_item(ddps_pkg::KIND_CMD, 32767, 0));
    queue_ticks(2);
    queue_item(make_item(ddps_pkg::KIND_CMD, -32768, 0));
    queue_ticks(2);
    queue_item(make_item(ddps_pkg::KIND_CMD, 11, 0));
    queue_ticks(1);
    queue_item(make_item(ddps_pkg::KIND_CMD, 10, 0));
    queue_ticks(1);
    queue_item(make_item(ddps_pkg::KIND_CMD, -200, 0));
    queue_ticks(1);
    queue_item(make_item(ddps_pkg::KIND_CMD, -11, -102));
    queue_ticks(2);
  endtask

  initial begin
    ddps_pkg::cfg_t c;
    int phase_start;
    regs.turn_threshold = ddps_pkg::THR_W'(102);
    regs.move_threshold = ddps_pkg::THR_W'(10);
    regs.turn_duty = 8'd70;
    regs.linear_gain = ddps_pkg::GAIN_W'(400);
    regs.duty_offset = 8'd60;
    regs.min_duty = 8'd55;
    regs.ramp_step = 8'd2;
    regs.timeout_ticks = 8'd50;
    for (int w = LEFT; w <= RIGHT; w++) begin
      wheel_req[w] = '0;
      wheel_st[w].level = '0;
      wheel_st[w].fwd_pin = 1'b1;
      wheel_st[w].rev_pin = 1'b1;
      wheel_st[w].reversing = 1'b0;
    end
    idle_ticks = '1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 1) begin
        c = '0;
        c.ramp_step = 8'd1;
        program_regs(c, 1'b0);
      end else if (ph == 2) begin
        c = '1;
        program_regs(c, 1'b1);
      end else if (ph == 3) begin
        c = '1;
        c.turn_threshold = '0;
        c.move_threshold = '0;
        c.min_duty = '0;
        program_regs(c, 1'b0);
      end else if (ph > 3) begin
        program_regs(random_regs(), 1'($urandom()));
      end
      phase_start = items_pushed;
      if (ph == 0) queue_directed();
      while (items_pushed - phase_start < ITEMS_PER_PHASE) queue_sequence();
      while (items_taken != items_pushed || expected_results.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    $display("Drove %0d items (%0d ticks) across %0d register writes phases plus reset values;",
             items_taken, ticks_taken, phases_run);
    $display("compared %0d duty/pin results, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
